>>> rtl/lcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcp_pkg;

  // Directory geometry.
  localparam int ENTRIES   = 16;
  localparam int KEY_BITS  = 64;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = IDX_W + 1;

  // Fixed widths of the words on the channels.
  localparam int KEY_W     = 64;
  localparam int SLOT_W    = 4;
  localparam int REF_W     = 8;
  localparam int STAMP_W   = 32;

  localparam logic [REF_W-1:0] REF_MAX = '1;

  // Operation codes.
  localparam logic OP_LOOKUP  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_COMMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan_en;
    logic pick_en;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_release;
    logic scan_last;
    logic out_blocked;
  } sts_t;

  // One result word.
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    logic              all_pinned;
    logic              released;
    logic [REF_W-1:0]  ref_count;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/lcp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one lookup or release per word.
interface lcp_req_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [lcp_pkg::KEY_W-1:0]    key;
  logic [lcp_pkg::SLOT_W-1:0]   release_slot;

  modport source (output valid, operation, key, release_slot, input ready);
  modport sink   (input valid, operation, key, release_slot, output ready);
endinterface

// Response channel: one result word per request.
interface lcp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [lcp_pkg::SLOT_W-1:0]   slot;
  logic                         evicted;
  logic [lcp_pkg::KEY_W-1:0]    evicted_key;
  logic                         all_pinned;
  logic                         released;
  logic [lcp_pkg::REF_W-1:0]    ref_count;

  modport source (output valid, hit, slot, evicted, evicted_key, all_pinned, released,
                  ref_count, input ready);
  modport sink   (input valid, hit, slot, evicted, evicted_key, all_pinned, released,
                  ref_count, output ready);
endinterface

`default_nettype wire

>>> rtl/lru_cache_with_pinning.sv
`timescale 1ns / 1ps
`default_nettype none

// Fully associative cache directory with LRU replacement and per-slot
// reference counts. Requests arrive on req_i (valid/ready): a lookup by
// key or a release of one slot's count. Each request gives exactly one
// response word on rsp_o (valid/ready).
// A lookup scans the sixteen entries one per cycle through the single
// read port of the key and stamp stores, then reads the chosen entry
// once more and commits.
// A release needs no scan and goes from acceptance straight to commit.
// One request is in flight at a time; ready is high only while the
// controller is idle. A new request is taken in the cycle after a commit.
// The response sits in an output register, so the
// next request is accepted while an earlier word still waits; a commit
// stalls only while that register is still full and not taken.
// Reset clears every valid mark, all counts and the access clock; the
// block takes requests in the first cycle after reset is released.
module lru_cache_with_pinning (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lcp_req_if.sink   req_i,
  lcp_rsp_if.source rsp_o
);

  lcp_pkg::cmd_t cmd;
  lcp_pkg::sts_t sts;
  lcp_pkg::rsp_t rsp;
  logic          in_ready;
  logic          out_valid;

  lcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lcp_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_operation_i    (req_i.operation),
    .in_key_i          (req_i.key),
    .in_release_slot_i (req_i.release_slot),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid),
    .out_ready_i       (rsp_o.ready),
    .out_rsp_o         (rsp)
  );

  // Channel hookup.
  assign req_i.ready       = in_ready;
  assign rsp_o.valid       = out_valid;
  assign rsp_o.hit         = rsp.hit;
  assign rsp_o.slot        = rsp.slot;
  assign rsp_o.evicted     = rsp.evicted;
  assign rsp_o.evicted_key = rsp.evicted_key;
  assign rsp_o.all_pinned  = rsp.all_pinned;
  assign rsp_o.released    = rsp.released;
  assign rsp_o.ref_count   = rsp.ref_count;

endmodule

`default_nettype wire

>>> rtl/lcp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lcp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output lcp_pkg::cmd_t      cmd_o,
  input  wire lcp_pkg::sts_t sts_i
);

  lcp_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      lcp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = sts_i.op_release ? lcp_pkg::ST_COMMIT : lcp_pkg::ST_SCAN;
        end
      end
      lcp_pkg::ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = lcp_pkg::ST_PICK;
        end
      end
      lcp_pkg::ST_PICK: begin
        cmd_o.pick_en = 1'b1;
        state_d = lcp_pkg::ST_COMMIT;
      end
      lcp_pkg::ST_COMMIT: begin
        if (!sts_i.out_blocked) begin
          cmd_o.commit = 1'b1;
          state_d = lcp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lcp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/lcp_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module lcp_dpath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Request word, sampled on capture.
  input  wire logic                       in_operation_i,
  input  wire logic [lcp_pkg::KEY_W-1:0]  in_key_i,
  input  wire logic [lcp_pkg::SLOT_W-1:0] in_release_slot_i,
  // Controller link.
  input  wire lcp_pkg::cmd_t              cmd_i,
  output lcp_pkg::sts_t                   sts_o,
  // Result register.
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output lcp_pkg::rsp_t                   out_rsp_o
);

  localparam int N  = lcp_pkg::ENTRIES;
  localparam int IW = lcp_pkg::IDX_W;
  localparam int CW = lcp_pkg::CNT_W;
  localparam int KB = lcp_pkg::KEY_BITS;
  localparam int RW = lcp_pkg::REF_W;
  localparam int SW = lcp_pkg::STAMP_W;

  // Request registers.
  logic                         op_q;
  logic [KB-1:0]                key_q;
  logic [lcp_pkg::SLOT_W-1:0]   rel_slot_q;

  // Per-entry state kept in flops.
  logic [N-1:0]                 valid_q;
  logic [RW-1:0]                refs_q [N];
  logic [SW-1:0]                clock_q;

  // Key and stamp stores with one registered read port.
  logic [KB-1:0]                key_mem   [N];
  logic [SW-1:0]                stamp_mem [N];
  logic [KB-1:0]                key_rd_q;
  logic [SW-1:0]                stamp_rd_q;
  logic [IW-1:0]                rd_addr;
  logic                         rd_en;

  // Scan state.
  logic [CW-1:0]                cnt_q;
  logic                         rd_vld_q;
  logic [IW-1:0]                rd_idx_q;
  logic                         found_q, free_q, victim_q;
  logic [IW-1:0]                hit_idx_q, free_idx_q, victim_idx_q;
  logic [SW-1:0]                oldest_q;
  logic [IW-1:0]                pick_sel, pick_q;

  // Result register.
  logic                         out_valid_q;
  lcp_pkg::rsp_t                rsp_q, rsp_d;

  // Commit-time decode.
  logic                         scan_more;
  logic                         evict, pinned;
  logic [RW-1:0]                pick_refs, new_refs;
  logic                         rel_in_range;
  logic [IW-1:0]                rel_idx;
  logic [RW-1:0]                rel_refs;
  logic                         rel_dec;
  logic                         commit_lookup, commit_release;

  assign scan_more      = (cnt_q < CW'(N));
  assign commit_lookup  = cmd_i.commit && (op_q == lcp_pkg::OP_LOOKUP);
  assign commit_release = cmd_i.commit && (op_q == lcp_pkg::OP_RELEASE);

  // Status toward the controller.
  assign sts_o.op_release  = (in_operation_i == lcp_pkg::OP_RELEASE);
  assign sts_o.scan_last   = !scan_more;
  assign sts_o.out_blocked = out_valid_q && !out_ready_i;

  // Capture the request word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= in_operation_i;
      key_q      <= in_key_i[KB-1:0];
      rel_slot_q <= in_release_slot_i;
    end
  end

  // The pick follows the order hit, free slot, oldest unpinned, slot zero.
  always_comb begin
    if (found_q) begin
      pick_sel = hit_idx_q;
    end else if (free_q) begin
      pick_sel = free_idx_q;
    end else if (victim_q) begin
      pick_sel = victim_idx_q;
    end else begin
      pick_sel = '0;
    end
  end

  // Read address walks the entries during the scan, then selects the pick.
  assign rd_addr = cmd_i.pick_en ? pick_sel : cnt_q[IW-1:0];
  assign rd_en   = (cmd_i.scan_en && scan_more) || cmd_i.pick_en;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      key_rd_q   <= key_mem[rd_addr];
      stamp_rd_q <= stamp_mem[rd_addr];
    end
  end

  // Store writes happen at commit of a lookup.
  always_ff @(posedge clk_i) begin
    if (commit_lookup && !found_q) begin
      key_mem[pick_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_lookup) begin
      stamp_mem[pick_q] <= clock_q;
    end
  end

  // Scan counter and read-data tag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else if (cmd_i.capture) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.scan_en) begin
      rd_vld_q <= scan_more;
      rd_idx_q <= cnt_q[IW-1:0];
      if (scan_more) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // Evaluate one entry per cycle for match, free slot and oldest unpinned.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q      <= 1'b0;
      free_q       <= 1'b0;
      victim_q     <= 1'b0;
      hit_idx_q    <= '0;
      free_idx_q   <= '0;
      victim_idx_q <= '0;
      oldest_q     <= '0;
    end else if (cmd_i.capture) begin
      found_q  <= 1'b0;
      free_q   <= 1'b0;
      victim_q <= 1'b0;
    end else if (cmd_i.scan_en && rd_vld_q) begin
      if (valid_q[rd_idx_q] && (key_rd_q == key_q) && !found_q) begin
        found_q   <= 1'b1;
        hit_idx_q <= rd_idx_q;
      end
      if (!valid_q[rd_idx_q] && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
      if (valid_q[rd_idx_q] && (refs_q[rd_idx_q] == '0) &&
          (!victim_q || (stamp_rd_q < oldest_q))) begin
        victim_q     <= 1'b1;
        victim_idx_q <= rd_idx_q;
        oldest_q     <= stamp_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick_en) begin
      pick_q <= pick_sel;
    end
  end

  // Commit decode for both operations.
  assign evict     = !found_q && !free_q;
  assign pinned    = evict && !victim_q;
  assign pick_refs = refs_q[pick_q];
  assign new_refs  = (pick_refs == lcp_pkg::REF_MAX) ? pick_refs : pick_refs + RW'(1);

  assign rel_in_range = (32'(rel_slot_q) < N);
  assign rel_idx      = IW'(rel_slot_q);
  assign rel_refs     = refs_q[rel_idx];
  assign rel_dec      = rel_in_range && (rel_refs != '0);

  always_comb begin
    rsp_d = '0;
    if (op_q == lcp_pkg::OP_LOOKUP) begin
      rsp_d.hit         = found_q;
      rsp_d.slot        = lcp_pkg::SLOT_W'(pick_q);
      rsp_d.evicted     = evict;
      rsp_d.evicted_key = evict ? lcp_pkg::KEY_W'(key_rd_q) : '0;
      rsp_d.all_pinned  = pinned;
      rsp_d.ref_count   = new_refs;
    end else begin
      rsp_d.slot     = rel_slot_q;
      rsp_d.released = rel_dec;
      if (rel_in_range) begin
        rsp_d.ref_count = rel_dec ? rel_refs - RW'(1) : rel_refs;
      end
    end
  end

  // Valid marks, counts and access clock.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      clock_q <= '0;
      for (int i = 0; i < N; i++) begin
        refs_q[i] <= '0;
      end
    end else if (commit_lookup) begin
      valid_q[pick_q] <= 1'b1;
      refs_q[pick_q]  <= new_refs;
      clock_q         <= clock_q + SW'(1);
    end else if (commit_release && rel_dec) begin
      refs_q[rel_idx] <= rel_refs - RW'(1);
    end
  end

  // Output register holds the word until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS   = 660;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int POOL_SIZE      = 24;
  localparam int N              = lcp_pkg::ENTRIES;
  localparam int KW             = lcp_pkg::KEY_W;
  localparam int SW             = lcp_pkg::SLOT_W;
  localparam int RW             = lcp_pkg::REF_W;
  localparam int TW             = lcp_pkg::STAMP_W;
  localparam logic [KW-1:0] KEY_MASK = {KW{1'b1}} >> (KW - lcp_pkg::KEY_BITS);

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lcp_req_if req_ch ();
  lcp_rsp_if rsp_ch ();

  lru_cache_with_pinning u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the directory, advanced once per accepted request word.
  bit            dir_valid [N] = '{default: 1'b0};
  logic [KW-1:0] dir_key   [N] = '{default: '0};
  logic [TW-1:0] dir_stamp [N] = '{default: '0};
  logic [RW-1:0] dir_refs  [N] = '{default: '0};
  logic [TW-1:0] dir_clock = '0;

  lcp_pkg::rsp_t pending_rsp_q [$];
  int            fault_count = 0;
  bit            no_idle     = 1'b0;

  function automatic logic [KW-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [SW-1:0] rand_slot();
    logic [31:0] r;
    r = $urandom_range(15);
    return r[SW-1:0];
  endfunction

  // Applies one request to the shadow directory and returns the word it should produce.
  function automatic lcp_pkg::rsp_t predict_directory(logic op, logic [KW-1:0] key,
                                                      logic [SW-1:0] rslot);
    lcp_pkg::rsp_t r;
    logic [KW-1:0] k;
    logic [TW-1:0] oldest;
    int            pick;
    bit            have_victim;
    r = '0;
    if (op == lcp_pkg::OP_RELEASE) begin
      r.slot = rslot;
      if (32'(rslot) < N) begin
        if (dir_refs[rslot] != '0) begin
          dir_refs[rslot] = dir_refs[rslot] - RW'(1);
          r.released = 1'b1;
        end
        r.ref_count = dir_refs[rslot];
      end
    end else begin
      k    = key & KEY_MASK;
      pick = -1;
      for (int i = 0; i < N; i++) begin
        if (pick < 0 && dir_valid[i] && dir_key[i] == k) pick = i;
      end
      if (pick >= 0) begin
        r.hit = 1'b1;
      end else begin
        // Miss: lowest free slot first, then the oldest unpinned one, else slot 0.
        for (int i = 0; i < N; i++) begin
          if (pick < 0 && !dir_valid[i]) pick = i;
        end
        if (pick < 0) begin
          have_victim = 1'b0;
          oldest      = '0;
          for (int i = 0; i < N; i++) begin
            if (dir_refs[i] == '0 && (!have_victim || dir_stamp[i] < oldest)) begin
              oldest      = dir_stamp[i];
              pick        = i;
              have_victim = 1'b1;
            end
          end
          if (!have_victim) begin
            pick         = 0;
            r.all_pinned = 1'b1;
          end
          r.evicted     = 1'b1;
          r.evicted_key = dir_key[pick];
        end
        dir_valid[pick] = 1'b1;
        dir_key[pick]   = k;
      end
      if (dir_refs[pick] != lcp_pkg::REF_MAX) dir_refs[pick] = dir_refs[pick] + RW'(1);
      dir_stamp[pick] = dir_clock;
      dir_clock       = dir_clock + TW'(1);
      r.slot          = pick[SW-1:0];
      r.ref_count     = dir_refs[pick];
    end
    return r;
  endfunction

  // Sends one request word, with an occasional pause beforehand, and records
  // the word it should produce. The valid stays high on return.
  task automatic send_request(input logic op, input logic [KW-1:0] key,
                              input logic [SW-1:0] rslot, output lcp_pkg::rsp_t predicted);
    if (!no_idle && $urandom_range(99) < 12) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(25, 1)) @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.key          <= key;
    req_ch.release_slot <= rslot;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    predicted = predict_directory(op, key, rslot);
    pending_rsp_q.push_back(predicted);
  endtask

  function automatic void check_field(string name, logic [KW-1:0] want,
                                      logic [KW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endfunction

  // Compares each accepted response word with the oldest prediction and
  // stalls the response channel at random.
  always @(posedge clk_i) begin : check_responses
    lcp_pkg::rsp_t want;
    if (rst_ni && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        $error("response word arrived with no request outstanding");
        fault_count++;
      end else begin
        want = pending_rsp_q.pop_front();
        check_field("hit", KW'(want.hit), KW'(rsp_ch.hit));
        check_field("slot", KW'(want.slot), KW'(rsp_ch.slot));
        check_field("evicted", KW'(want.evicted), KW'(rsp_ch.evicted));
        check_field("evicted_key", want.evicted_key, rsp_ch.evicted_key);
        check_field("all_pinned", KW'(want.all_pinned), KW'(rsp_ch.all_pinned));
        check_field("released", KW'(want.released), KW'(rsp_ch.released));
        check_field("ref_count", KW'(want.ref_count), KW'(rsp_ch.ref_count));
      end
    end
    rsp_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 12);
  end

  // Ends the run when neither channel has moved a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  // Fills every slot, the first six with extreme and patterned keys, the rest with random keys.
  task automatic test_fill();
    logic [KW-1:0] keys [6];
    lcp_pkg::rsp_t unused;
    keys = '{64'h0, {KW{1'b1}}, 64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555,
             64'hAAAA_AAAA_AAAA_AAAA, 64'h0123_4567_89AB_CDEF};
    for (int i = 0; i < N; i++) begin
      send_request(lcp_pkg::OP_LOOKUP, (i < 6) ? keys[i] : rand_key(), rand_slot(), unused);
    end
  endtask

  // Hits on cached keys raise their counts and refresh their stamps.
  task automatic test_hits();
    lcp_pkg::rsp_t unused;
    send_request(lcp_pkg::OP_LOOKUP, {KW{1'b1}}, rand_slot(), unused);
    send_request(lcp_pkg::OP_LOOKUP, 64'h0, rand_slot(), unused);
    send_request(lcp_pkg::OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, rand_slot(), unused);
  endtask

  // Every slot is referenced, so a miss must overwrite slot 0.
  task automatic test_all_pinned();
    lcp_pkg::rsp_t unused;
    send_request(lcp_pkg::OP_LOOKUP, 64'hFEED_F00D_0BAD_CAFE, rand_slot(), unused);
  endtask

  // Releases down to zero, a release of a zero count, then a miss that takes
  // the older of the two unpinned slots.
  task automatic test_release();
    lcp_pkg::rsp_t unused;
    send_request(lcp_pkg::OP_RELEASE, rand_key(), 4'd5, unused);
    send_request(lcp_pkg::OP_RELEASE, rand_key(), 4'd5, unused);
    send_request(lcp_pkg::OP_RELEASE, rand_key(), 4'd15, unused);
    send_request(lcp_pkg::OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFE, rand_slot(), unused);
  endtask

  // Drives one slot's count past its maximum, then releases it back to zero.
  task automatic test_count_saturation();
    logic [KW-1:0] k;
    lcp_pkg::rsp_t got;
    k = rand_key();
    for (int i = 0; i < 260; i++) send_request(lcp_pkg::OP_LOOKUP, k, rand_slot(), got);
    for (int i = 0; i < 257; i++) send_request(lcp_pkg::OP_RELEASE, rand_key(), got.slot, got);
  endtask

  // Lookups from a small, slowly changing key pool mixed with releases, so
  // that hits, evictions and pinned slots all keep occurring.
  task automatic test_random_traffic();
    logic [KW-1:0] pool [POOL_SIZE];
    lcp_pkg::rsp_t unused;
    int            pick;
    foreach (pool[i]) pool[i] = rand_key();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 250 && n < 450);
      if ($urandom_range(99) < 55) begin
        send_request(lcp_pkg::OP_RELEASE, rand_key(), rand_slot(), unused);
      end else begin
        pick = $urandom_range(POOL_SIZE - 1);
        if ($urandom_range(99) < 6) pool[pick] = rand_key();
        send_request(lcp_pkg::OP_LOOKUP, pool[pick], rand_slot(), unused);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    req_ch.valid        <= 1'b0;
    req_ch.operation    <= lcp_pkg::OP_LOOKUP;
    req_ch.key          <= '0;
    req_ch.release_slot <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_fill();
    test_hits();
    test_all_pinned();
    test_release();
    test_count_saturation();
    test_random_traffic();
    req_ch.valid <= 1'b0;

    // Let the last words drain before the verdict.
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
